// ----- src/fdsa_pkg.sv -----
// fdsa_pkg: opcodes, fault codes and controller/datapath link types
// for the forth data stack alu; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fdsa_pkg;

  localparam logic [4:0] OP_PUSH   = 5'd0;
  localparam logic [4:0] OP_DROP   = 5'd1;
  localparam logic [4:0] OP_DUP    = 5'd2;
  localparam logic [4:0] OP_QDUP   = 5'd3;
  localparam logic [4:0] OP_OVER   = 5'd4;
  localparam logic [4:0] OP_SWAP   = 5'd5;
  localparam logic [4:0] OP_ROT    = 5'd6;
  localparam logic [4:0] OP_PICK   = 5'd7;
  localparam logic [4:0] OP_ADD    = 5'd8;
  localparam logic [4:0] OP_SUB    = 5'd9;
  localparam logic [4:0] OP_MUL    = 5'd10;
  localparam logic [4:0] OP_DIVMOD = 5'd11;
  localparam logic [4:0] OP_AND    = 5'd12;
  localparam logic [4:0] OP_OR     = 5'd13;
  localparam logic [4:0] OP_XOR    = 5'd14;
  localparam logic [4:0] OP_NOT    = 5'd15;
  localparam logic [4:0] OP_INVERT = 5'd16;
  localparam logic [4:0] OP_NEGATE = 5'd17;
  localparam logic [4:0] OP_EQ     = 5'd18;
  localparam logic [4:0] OP_NE     = 5'd19;
  localparam logic [4:0] OP_LT     = 5'd20;
  localparam logic [4:0] OP_GT     = 5'd21;
  localparam logic [4:0] OP_LE     = 5'd22;
  localparam logic [4:0] OP_GE     = 5'd23;
  localparam logic [4:0] OP_MIN    = 5'd24;
  localparam logic [4:0] OP_MAX    = 5'd25;
  localparam logic [4:0] OP_DEPTH  = 5'd26;

  localparam logic [1:0] FLT_OK    = 2'd0;
  localparam logic [1:0] FLT_UNDER = 2'd1;
  localparam logic [1:0] FLT_OVER  = 2'd2;
  localparam logic [1:0] FLT_DIV0  = 2'd3;

  typedef struct packed {
    logic load;
    logic eval;
    logic commit;
    logic div_start;
    logic div_step;
    logic fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] fault;
    logic       need_rd;
    logic       is_div;
    logic       div_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- src/fdsa_in_if.sv -----
// fdsa_in_if: command channel (primitive and literal) with valid/ready
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface fdsa_in_if;
  logic              valid;
  logic              ready;
  logic [4:0]        cmd;
  logic signed [15:0] literal;

  modport source (output valid, output cmd, output literal, input ready);
  modport sink   (input valid, input cmd, input literal, output ready);
endinterface

`default_nettype wire

// ----- src/fdsa_out_if.sv -----
// fdsa_out_if: result channel (top cells, depth, fault) with valid/ready
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface fdsa_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] top_cell;
  logic signed [15:0] second_cell;
  logic [5:0]         stack_depth;
  logic [1:0]         fault;

  modport source (output valid, output top_cell, output second_cell,
                  output stack_depth, output fault, input ready);
  modport sink   (input valid, input top_cell, input second_cell,
                  input stack_depth, input fault, output ready);
endinterface

`default_nettype wire

// ----- src/fdsa_ram.sv -----
// fdsa_ram: generic single write port, single read port ram
// with registered read data; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module fdsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- src/fdsa_datapath.sv -----
// fdsa_datapath: top/second cell registers, stack ram below them, alu,
// fault checks and iterative divider; uses fdsa_pkg and fdsa_ram
`timescale 1ns / 1ps
`default_nettype none

module fdsa_datapath #(
  parameter int STACK_DEPTH = 32,
  parameter int CELL_WIDTH  = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [4:0]         cmd_i,
  input  wire logic signed [15:0] literal_i,
  input  fdsa_pkg::ctrl_cmd_t     cm_i,
  output fdsa_pkg::dp_status_t    st_o,
  output logic signed [15:0]      top_cell_o,
  output logic signed [15:0]      second_cell_o,
  output logic [5:0]              stack_depth_o,
  output logic [1:0]              fault_o
);

  localparam int W    = CELL_WIDTH;
  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int DW   = $clog2(STACK_DEPTH + 1);
  localparam int XW   = ((W > DW) ? W : DW) + 1;
  localparam int CNTW = $clog2(CELL_WIDTH + 1);

  logic [4:0]      cmd_q;
  logic [W-1:0]    lit_q;
  logic [W-1:0]    tos_q, tos_d;
  logic [W-1:0]    nos_q, nos_d;
  logic [DW-1:0]   depth_q, depth_d;
  logic [1:0]      fault_q;
  logic [W-1:0]    rem_q, quo_q, dvs_q;
  logic            qneg_q, rneg_q;
  logic [CNTW-1:0] cnt_q;

  logic [W-1:0]    a, b, r, rd, push_val;
  logic [2*W-1:0]  prod;
  logic            tos_zero, grow, is_bin, do_push, lt, gt, eq;
  logic [1:0]      need, fault_c;
  logic [XW-1:0]   pick_idx, depth_x;
  logic            pick_bad;
  logic [DW-1:0]   third_idx, sec_idx;
  logic [AW-1:0]   raddr, waddr;
  logic [W-1:0]    wdata;
  logic            we;
  logic [W:0]      remw, diff;
  logic [W-1:0]    q_fin, r_fin;

  assign a        = nos_q;
  assign b        = tos_q;
  assign tos_zero = (b == '0);
  assign eq       = (a == b);
  assign lt       = ($signed(a) < $signed(b));
  assign gt       = ($signed(a) > $signed(b));
  assign prod     = a * b;
  assign depth_x  = XW'(depth_q);
  assign pick_idx = depth_x - XW'(2) - XW'(b);
  assign pick_bad = b[W-1] || (XW'(b) >= (depth_x - XW'(1)));
  assign third_idx = depth_q - DW'(3);
  assign sec_idx   = depth_q - DW'(2);

  always_comb begin
    need   = 2'd2;
    grow   = 1'b0;
    is_bin = 1'b0;
    r      = '0;
    case (cmd_q)
      fdsa_pkg::OP_PUSH, fdsa_pkg::OP_DEPTH: begin
        need = 2'd0;
        grow = 1'b1;
      end
      fdsa_pkg::OP_DUP, fdsa_pkg::OP_QDUP: begin
        need = 2'd1;
        grow = 1'b1;
      end
      fdsa_pkg::OP_OVER: grow = 1'b1;
      fdsa_pkg::OP_DROP, fdsa_pkg::OP_PICK, fdsa_pkg::OP_NOT,
      fdsa_pkg::OP_INVERT, fdsa_pkg::OP_NEGATE: need = 2'd1;
      fdsa_pkg::OP_ROT: need = 2'd3;
      fdsa_pkg::OP_SWAP, fdsa_pkg::OP_DIVMOD: need = 2'd2;
      fdsa_pkg::OP_ADD: begin is_bin = 1'b1; r = a + b; end
      fdsa_pkg::OP_SUB: begin is_bin = 1'b1; r = a - b; end
      fdsa_pkg::OP_MUL: begin is_bin = 1'b1; r = prod[W-1:0]; end
      fdsa_pkg::OP_AND: begin is_bin = 1'b1; r = a & b; end
      fdsa_pkg::OP_OR:  begin is_bin = 1'b1; r = a | b; end
      fdsa_pkg::OP_XOR: begin is_bin = 1'b1; r = a ^ b; end
      fdsa_pkg::OP_EQ:  begin is_bin = 1'b1; r = {W{eq}}; end
      fdsa_pkg::OP_NE:  begin is_bin = 1'b1; r = {W{!eq}}; end
      fdsa_pkg::OP_LT:  begin is_bin = 1'b1; r = {W{lt}}; end
      fdsa_pkg::OP_GT:  begin is_bin = 1'b1; r = {W{gt}}; end
      fdsa_pkg::OP_LE:  begin is_bin = 1'b1; r = {W{!gt}}; end
      fdsa_pkg::OP_GE:  begin is_bin = 1'b1; r = {W{!lt}}; end
      fdsa_pkg::OP_MIN: begin is_bin = 1'b1; r = lt ? a : b; end
      fdsa_pkg::OP_MAX: begin is_bin = 1'b1; r = gt ? a : b; end
      default: need = 2'd0;
    endcase
  end

  always_comb begin
    if (depth_q < DW'(need)) begin
      fault_c = fdsa_pkg::FLT_UNDER;
    end else if (grow && (depth_q == DW'(STACK_DEPTH)) &&
                 !((cmd_q == fdsa_pkg::OP_QDUP) && tos_zero)) begin
      fault_c = fdsa_pkg::FLT_OVER;
    end else if ((cmd_q == fdsa_pkg::OP_PICK) && pick_bad) begin
      fault_c = fdsa_pkg::FLT_UNDER;
    end else if ((cmd_q == fdsa_pkg::OP_DIVMOD) && tos_zero) begin
      fault_c = fdsa_pkg::FLT_DIV0;
    end else begin
      fault_c = fdsa_pkg::FLT_OK;
    end
  end

  assign st_o.fault    = fault_c;
  assign st_o.need_rd  = is_bin || (cmd_q == fdsa_pkg::OP_DROP) ||
                         (cmd_q == fdsa_pkg::OP_ROT) ||
                         ((cmd_q == fdsa_pkg::OP_PICK) && !tos_zero);
  assign st_o.is_div   = (cmd_q == fdsa_pkg::OP_DIVMOD);
  assign st_o.div_done = (cnt_q == '0);

  assign raddr = (cmd_q == fdsa_pkg::OP_PICK) ? pick_idx[AW-1:0] : third_idx[AW-1:0];

  // restoring divide step on magnitudes
  assign remw  = {rem_q, quo_q[W-1]};
  assign diff  = remw - {1'b0, dvs_q};
  assign q_fin = qneg_q ? (W'(0) - quo_q) : quo_q;
  assign r_fin = rneg_q ? (W'(0) - rem_q) : rem_q;

  always_comb begin
    push_val = b;
    do_push  = 1'b0;
    case (cmd_q)
      fdsa_pkg::OP_PUSH:  begin do_push = 1'b1; push_val = lit_q; end
      fdsa_pkg::OP_DUP:   do_push = 1'b1;
      fdsa_pkg::OP_QDUP:  do_push = !tos_zero;
      fdsa_pkg::OP_OVER:  begin do_push = 1'b1; push_val = a; end
      fdsa_pkg::OP_DEPTH: begin do_push = 1'b1; push_val = depth_x[W-1:0]; end
      default: do_push = 1'b0;
    endcase
  end

  always_comb begin
    tos_d   = tos_q;
    nos_d   = nos_q;
    depth_d = depth_q;
    we      = 1'b0;
    waddr   = sec_idx[AW-1:0];
    wdata   = a;
    if (do_push) begin
      tos_d   = push_val;
      nos_d   = b;
      depth_d = depth_q + DW'(1);
      we      = (depth_q >= DW'(2));
    end else if (is_bin) begin
      tos_d   = r;
      nos_d   = rd;
      depth_d = depth_q - DW'(1);
    end else begin
      case (cmd_q)
        fdsa_pkg::OP_DROP: begin
          tos_d   = a;
          nos_d   = rd;
          depth_d = depth_q - DW'(1);
        end
        fdsa_pkg::OP_SWAP: begin
          tos_d = a;
          nos_d = b;
        end
        fdsa_pkg::OP_ROT: begin
          tos_d = rd;
          nos_d = b;
          we    = 1'b1;
          waddr = third_idx[AW-1:0];
        end
        fdsa_pkg::OP_PICK:   tos_d = tos_zero ? a : rd;
        fdsa_pkg::OP_NOT:    tos_d = W'(tos_zero);
        fdsa_pkg::OP_INVERT: tos_d = ~b;
        fdsa_pkg::OP_NEGATE: tos_d = W'(0) - b;
        fdsa_pkg::OP_DIVMOD: begin
          tos_d = q_fin;
          nos_d = r_fin;
        end
        default: tos_d = tos_q;
      endcase
    end
  end

  fdsa_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we && cm_i.commit),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      cnt_q   <= '0;
    end else begin
      if (cm_i.commit) begin
        depth_q <= depth_d;
      end
      if (cm_i.div_start) begin
        cnt_q <= CNTW'(W);
      end else if (cm_i.div_step && (cnt_q != '0)) begin
        cnt_q <= cnt_q - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cm_i.load) begin
      cmd_q <= cmd_i;
      lit_q <= W'(literal_i);
    end
    if (cm_i.eval) begin
      fault_q <= fault_c;
    end
    if (cm_i.commit) begin
      tos_q <= tos_d;
      nos_q <= nos_d;
    end
    if (cm_i.div_start) begin
      dvs_q  <= b[W-1] ? (W'(0) - b) : b;
      quo_q  <= a[W-1] ? (W'(0) - a) : a;
      rem_q  <= '0;
      qneg_q <= a[W-1] ^ b[W-1];
      rneg_q <= a[W-1];
    end else if (cm_i.div_step && (cnt_q != '0)) begin
      rem_q <= diff[W] ? remw[W-1:0] : diff[W-1:0];
      quo_q <= {quo_q[W-2:0], !diff[W]};
    end
    if (cm_i.fin) begin
      top_cell_o    <= (depth_q >= DW'(1)) ? 16'(tos_q) : 16'sd0;
      second_cell_o <= (depth_q >= DW'(2)) ? 16'(nos_q) : 16'sd0;
      stack_depth_o <= 6'(depth_q);
      fault_o       <= fault_q;
    end
  end

endmodule

`default_nettype wire

// ----- src/fdsa_ctrl.sv -----
// fdsa_ctrl: sequencing state machine and handshake control
// for the forth data stack alu; uses fdsa_pkg
`timescale 1ns / 1ps
`default_nettype none

module fdsa_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  fdsa_pkg::dp_status_t  st_i,
  output fdsa_pkg::ctrl_cmd_t   cm_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD,
    S_DIV,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cm_o    = '0;
    case (state_q)
      S_IDLE: begin
        cm_o.load = in_valid_i && in_ready_o;
        if (cm_o.load) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cm_o.eval = 1'b1;
        if (st_i.fault != fdsa_pkg::FLT_OK) begin
          state_d = S_FIN;
        end else if (st_i.need_rd) begin
          state_d = S_RD;
        end else if (st_i.is_div) begin
          cm_o.div_start = 1'b1;
          state_d        = S_DIV;
        end else begin
          cm_o.commit = 1'b1;
          state_d     = S_FIN;
        end
      end
      S_RD: begin
        cm_o.commit = 1'b1;
        state_d     = S_FIN;
      end
      S_DIV: begin
        cm_o.div_step = 1'b1;
        if (st_i.div_done) begin
          cm_o.commit = 1'b1;
          state_d     = S_FIN;
        end
      end
      S_FIN: begin
        cm_o.fin = 1'b1;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FIN) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_fin_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |-> (!out_valid_q || out_ready_i))
    else $error("result register busy at finish");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted command not executed");

  a_one_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cm_o.commit |=> !cm_o.commit)
    else $error("two commits for one command");

  a_fin_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |=> out_valid_q)
    else $error("finished command gave no result");
`endif

endmodule

`default_nettype wire

// ----- src/forth_data_stack_alu_core.sv -----
// channel  dir  signals                                      transfer
// in_ch    in   valid ready cmd literal                      valid && ready
// out_ch   out  valid ready top_cell second_cell             valid && ready
//               stack_depth fault
//
// one command at a time: accept in S_IDLE, then check and execute in S_EXEC
// (push/dup/swap/unary or a faulted command), S_RD for ops that read the stack
// ram, S_DIV for the divmod steps, then S_FIN loads the result register
// the next command is taken only when the result register is empty or transfers
// reset clears depth and control only; the stack ram needs no clearing
// uses fdsa_pkg, fdsa_in_if, fdsa_out_if, fdsa_ctrl, fdsa_datapath
`timescale 1ns / 1ps
`default_nettype none

module forth_data_stack_alu_core #(
  parameter int STACK_DEPTH = 32,
  parameter int CELL_WIDTH  = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  fdsa_in_if.sink         in_ch,
  fdsa_out_if.source      out_ch
);

  fdsa_pkg::ctrl_cmd_t  cm;
  fdsa_pkg::dp_status_t st;

  fdsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .st_i        (st),
    .cm_o        (cm)
  );

  fdsa_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .CELL_WIDTH  (CELL_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (in_ch.cmd),
    .literal_i     (in_ch.literal),
    .cm_i          (cm),
    .st_o          (st),
    .top_cell_o    (out_ch.top_cell),
    .second_cell_o (out_ch.second_cell),
    .stack_depth_o (out_ch.stack_depth),
    .fault_o       (out_ch.fault)
  );

endmodule

`default_nettype wire
